/* hdl/dci_pkg.sv */
package dci_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CFG_W      = 5;
   localparam int Q_W        = 17;
   localparam int PROD_W     = 2 * (Q_W + 1);
   localparam int MAG_W      = 2 * Q_W;
   localparam int DCNT_W     = $clog2(MAG_W + 1);
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   localparam logic [Q_W-1:0] Q_ONE  = Q_W'(65536);
   localparam logic [Q_W-1:0] Q_ZERO = '0;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [Q_W-1:0]   divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_stat_type;

   function automatic logic [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
      logic [Q_W-1:0] r;
      if (v < 0) begin
         r = Q_ZERO;
      end else if (v > $signed(PROD_W'(Q_ONE))) begin
         r = Q_ONE;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/depletion_curve_interpolator.sv */
// After a load beat the block is ready again on the next cycle.
// A query of 0 or of 1.0 and above gives its result on the cycle after acceptance.
// Other queries scan the table entry by entry through the FETCH and CHECK states,
// then use the multiply and the 34-step serial divider.
// One query is in flight at a time. Synchronous reset sets point_count to one and
// idles the sequencer; the table holds no reset value.
module depletion_curve_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_index[3:0], point_x[20:4], point_y[37:21], query_x[54:38], zero pad.
   input  logic [dci_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd.
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // curve_value[16:0], zero pad.
   output logic [dci_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // interpolated.
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [dci_pkg::CFG_W-1:0]        csr_wdata
);

   dci_pkg::state_type              state_ff, state_in;
   logic [dci_pkg::CFG_W-1:0]       count_ff;
   logic [dci_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [dci_pkg::Q_W-1:0]         q_ff, q_in;
   logic [dci_pkg::Q_W-1:0]         x0_ff, x0_in;
   logic [dci_pkg::Q_W-1:0]         y0_ff, y0_in;
   logic [dci_pkg::Q_W-1:0]         yfirst_ff, yfirst_in;
   logic signed [dci_pkg::Q_W:0]    dy_ff, dy_in;
   logic signed [dci_pkg::Q_W:0]    dx_ff, dx_in;
   logic signed [dci_pkg::Q_W:0]    den_ff, den_in;
   logic signed [dci_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                            neg_ff, neg_in;
   logic [dci_pkg::Q_W-1:0]         value_ff, value_in;
   logic                            flag_ff, flag_in;

   logic [dci_pkg::CNT_W-1:0]       n_eff;
   logic                            accept;
   logic [3:0]                      f_index;
   logic [dci_pkg::Q_W-1:0]         f_x;
   logic [dci_pkg::Q_W-1:0]         f_y;
   logic [dci_pkg::Q_W-1:0]         f_q;
   logic                            wr_en;
   logic [dci_pkg::Q_W-1:0]         rd_x;
   logic [dci_pkg::Q_W-1:0]         rd_y;
   logic signed [dci_pkg::PROD_W-1:0] prod_mag;
   logic signed [dci_pkg::Q_W:0]    den_mag;
   logic signed [dci_pkg::PROD_W-1:0] y_ext;
   logic signed [dci_pkg::PROD_W-1:0] quo_ext;
   logic signed [dci_pkg::PROD_W-1:0] sum;
   dci_pkg::div_ctrl_type           div_ctrl;
   dci_pkg::div_stat_type           div_stat;

   assign f_index = req_tdata[3:0];
   assign f_x     = req_tdata[20:4];
   assign f_y     = req_tdata[37:21];
   assign f_q     = req_tdata[54:38];

   assign req_tready = (state_ff == dci_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (req_tuser == dci_pkg::CMD_LOAD)
                       && (32'(f_index) < dci_pkg::MAX_POINTS);

   always_comb begin
      if (count_ff == '0) begin
         n_eff = dci_pkg::CNT_W'(1);
      end else if (32'(count_ff) > dci_pkg::MAX_POINTS) begin
         n_eff = dci_pkg::CNT_W'(dci_pkg::MAX_POINTS);
      end else begin
         n_eff = dci_pkg::CNT_W'(count_ff);
      end
   end

   dci_curve_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dci_pkg::IDX_W'(f_index)),
      .wr_x    (f_x),
      .wr_y    (f_y),
      .rd_addr (idx_ff[dci_pkg::IDX_W-1:0]),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   dci_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign prod_mag = prod_ff[dci_pkg::PROD_W-1] ? -prod_ff : prod_ff;
   assign den_mag  = den_ff[dci_pkg::Q_W] ? -den_ff : den_ff;
   assign y_ext    = $signed(dci_pkg::PROD_W'(y0_ff));
   assign quo_ext  = $signed(dci_pkg::PROD_W'(div_stat.quotient));
   assign sum      = neg_ff ? (y_ext - quo_ext) : (y_ext + quo_ext);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      q_in      = q_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      yfirst_in = yfirst_ff;
      dy_in     = dy_ff;
      dx_in     = dx_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      value_in  = value_ff;
      flag_in   = flag_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = prod_mag[dci_pkg::MAG_W-1:0];
      div_ctrl.divisor  = den_mag[dci_pkg::Q_W-1:0];
      case (state_ff)
         dci_pkg::ST_IDLE: begin
            if (accept && (req_tuser == dci_pkg::CMD_QUERY)) begin
               q_in    = f_q;
               idx_in  = '0;
               flag_in = 1'b0;
               if (f_q >= dci_pkg::Q_ONE) begin
                  value_in = dci_pkg::Q_ONE;
                  state_in = dci_pkg::ST_OUT;
               end else if (f_q == dci_pkg::Q_ZERO) begin
                  value_in = dci_pkg::Q_ZERO;
                  state_in = dci_pkg::ST_OUT;
               end else begin
                  state_in = dci_pkg::ST_FETCH;
               end
            end
         end
         dci_pkg::ST_FETCH: begin
            state_in = dci_pkg::ST_CHECK;
         end
         dci_pkg::ST_CHECK: begin
            if (idx_ff == '0) begin
               x0_in     = rd_x;
               y0_in     = rd_y;
               yfirst_in = rd_y;
               if (n_eff == dci_pkg::CNT_W'(1)) begin
                  value_in = dci_pkg::sat_q($signed(dci_pkg::PROD_W'(rd_y)));
                  state_in = dci_pkg::ST_OUT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = dci_pkg::ST_FETCH;
               end
            end else if (rd_x >= q_ff) begin
               if (rd_x == x0_ff) begin
                  value_in = dci_pkg::sat_q($signed(dci_pkg::PROD_W'(y0_ff)));
                  state_in = dci_pkg::ST_OUT;
               end else begin
                  dy_in    = $signed({1'b0, rd_y}) - $signed({1'b0, y0_ff});
                  dx_in    = $signed({1'b0, q_ff}) - $signed({1'b0, x0_ff});
                  den_in   = $signed({1'b0, rd_x}) - $signed({1'b0, x0_ff});
                  state_in = dci_pkg::ST_MUL;
               end
            end else if (dci_pkg::CNT_W'(idx_ff + 1'b1) == n_eff) begin
               value_in = dci_pkg::sat_q($signed(dci_pkg::PROD_W'(yfirst_ff)));
               state_in = dci_pkg::ST_OUT;
            end else begin
               x0_in    = rd_x;
               y0_in    = rd_y;
               idx_in   = idx_ff + 1'b1;
               state_in = dci_pkg::ST_FETCH;
            end
         end
         dci_pkg::ST_MUL: begin
            prod_in  = dy_ff * dx_ff;
            state_in = dci_pkg::ST_DIV_START;
         end
         dci_pkg::ST_DIV_START: begin
            div_ctrl.start = 1'b1;
            neg_in   = prod_ff[dci_pkg::PROD_W-1] ^ den_ff[dci_pkg::Q_W];
            state_in = dci_pkg::ST_DIV_WAIT;
         end
         dci_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = dci_pkg::ST_FINISH;
            end
         end
         dci_pkg::ST_FINISH: begin
            value_in = dci_pkg::sat_q(sum);
            flag_in  = 1'b1;
            state_in = dci_pkg::ST_OUT;
         end
         dci_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = dci_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dci_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      yfirst_ff <= yfirst_in;
      dy_ff     <= dy_in;
      dx_ff     <= dx_in;
      den_ff    <= den_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      value_ff  <= value_in;
      flag_ff   <= flag_in;
      if (reset) begin
         state_ff <= dci_pkg::ST_IDLE;
         idx_ff   <= '0;
         count_ff <= dci_pkg::CFG_W'(1);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = (state_ff == dci_pkg::ST_OUT);
   assign rsp_tdata  = dci_pkg::RSP_DATA_W'(value_ff);
   assign rsp_tuser  = flag_ff;

endmodule

/* hdl/dci_curve_mem.sv */
module dci_curve_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [dci_pkg::IDX_W-1:0]   wr_addr,
   input  logic [dci_pkg::Q_W-1:0]     wr_x,
   input  logic [dci_pkg::Q_W-1:0]     wr_y,
   input  logic [dci_pkg::IDX_W-1:0]   rd_addr,
   output logic [dci_pkg::Q_W-1:0]     rd_x,
   output logic [dci_pkg::Q_W-1:0]     rd_y
);

   logic [dci_pkg::Q_W-1:0] curve_x_ff [dci_pkg::MAX_POINTS];
   logic [dci_pkg::Q_W-1:0] curve_y_ff [dci_pkg::MAX_POINTS];
   logic [dci_pkg::Q_W-1:0] rd_x_ff;
   logic [dci_pkg::Q_W-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         curve_x_ff[wr_addr] <= wr_x;
         curve_y_ff[wr_addr] <= wr_y;
      end
      rd_x_ff <= curve_x_ff[rd_addr];
      rd_y_ff <= curve_y_ff[rd_addr];
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

/* hdl/dci_divider.sv */
module dci_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  dci_pkg::div_ctrl_type ctrl,
   output dci_pkg::div_stat_type stat
);

   logic [dci_pkg::Q_W:0]      rem_ff, rem_in;
   logic [dci_pkg::MAG_W-1:0]  quo_ff, quo_in;
   logic [dci_pkg::Q_W-1:0]    den_ff, den_in;
   logic [dci_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [dci_pkg::Q_W:0]      trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[dci_pkg::Q_W-1:0], quo_ff[dci_pkg::MAG_W-1]};
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = ctrl.dividend;
         den_in  = ctrl.divisor;
         cnt_in  = dci_pkg::DCNT_W'(dci_pkg::MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[dci_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[dci_pkg::MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == dci_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

/* hdl/dci_checker.sv */
module dci_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [dci_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dci_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   // A result beat waiting for the sink must hold still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Only one query is in flight, so the block never takes a beat while a result waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[dci_pkg::Q_W-1:0] <= dci_pkg::Q_ONE)
                     && (rsp_tdata[dci_pkg::RSP_DATA_W-1:dci_pkg::Q_W] == '0))
      else $error("result out of range");

   // A query at or above 1.0 answers 1.0 on the following cycle.
   a_clamp_high: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == dci_pkg::CMD_QUERY) && req_tdata[54]
      |=> rsp_tvalid && (rsp_tdata[dci_pkg::Q_W-1:0] == dci_pkg::Q_ONE) && !rsp_tuser)
      else $error("high clamp result wrong");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == dci_pkg::CMD_LOAD) |=> req_tready)
      else $error("load beat stalled the block");

endmodule

bind depletion_curve_interpolator dci_checker u_dci_checker (.*);

/* test/curve_lookup_check.sv */
`timescale 1ns / 1ps

module curve_lookup_check
   import dci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    answered,
   output int                    interpolated_seen
);

   typedef struct packed {
      logic [Q_W-1:0] level;
      logic           interp;
   } curve_answer_t;

   logic [CFG_W-1:0] point_count;
   logic [Q_W-1:0]   curve_x [MAX_POINTS];
   logic [Q_W-1:0]   curve_y [MAX_POINTS];
   curve_answer_t    awaited_levels [$];

   function automatic logic [Q_W-1:0] clamp_unit(input longint v);
      if (v < 0) begin
         return Q_ZERO;
      end
      if (v > longint'(Q_ONE)) begin
         return Q_ONE;
      end
      return v[Q_W-1:0];
   endfunction

   function automatic curve_answer_t interpolate_curve(input logic [Q_W-1:0] q);
      curve_answer_t a;
      int            span;
      bit            found;
      longint        x0, y0, x1, y1, num;
      a.interp = 1'b0;
      if (q >= Q_ONE) begin
         a.level = Q_ONE;
      end else if (q == Q_ZERO) begin
         a.level = Q_ZERO;
      end else begin
         span = (point_count == 0) ? 1 :
                (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
         a.level = clamp_unit(longint'(curve_y[0]));
         found = 1'b0;
         for (int i = 1; i < span && !found; i++) begin
            if (curve_x[i] >= q) begin
               found = 1'b1;
               x0 = longint'(curve_x[i-1]);
               y0 = longint'(curve_y[i-1]);
               x1 = longint'(curve_x[i]);
               y1 = longint'(curve_y[i]);
               if (x1 == x0) begin
                  a.level = clamp_unit(y0);
               end else begin
                  num = (y1 - y0) * (longint'(q) - x0);
                  a.level = clamp_unit(y0 + num / (x1 - x0));
                  a.interp = 1'b1;
               end
            end
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      curve_answer_t    want;
      logic [IDX_W-1:0] idx;
      if (reset) begin
         point_count = CFG_W'(1);
         for (int i = 0; i < MAX_POINTS; i++) begin
            curve_x[i] = Q_ZERO;
            curve_y[i] = Q_ZERO;
         end
         awaited_levels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            answered++;
            if (awaited_levels.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with no query waiting, got value %0d flag %0b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = awaited_levels.pop_front();
               if (want.interp) begin
                  interpolated_seen++;
               end
               if (rsp_tdata !== RSP_DATA_W'(want.level)) begin
                  fail_count++;
                  $display("%0t: curve_value expected %0d, got %0d",
                           $time, want.level, rsp_tdata);
               end
               if (rsp_tuser !== want.interp) begin
                  fail_count++;
                  $display("%0t: interpolated expected %0b, got %0b",
                           $time, want.interp, rsp_tuser);
               end
            end
         end
         if (csr_we) begin
            point_count = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[IDX_W-1:0];
            if (req_tuser == CMD_LOAD) begin
               curve_x[idx] = req_tdata[IDX_W +: Q_W];
               curve_y[idx] = req_tdata[IDX_W+Q_W +: Q_W];
            end else begin
               awaited_levels.push_back(interpolate_curve(req_tdata[IDX_W+2*Q_W +: Q_W]));
            end
         end
      end
      outstanding = awaited_levels.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import dci_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   int fail_count, outstanding, answered, interpolated_seen;
   int loads_sent, queries_sent, settings_seen;
   bit quiet;
   bit stall_request;
   logic [Q_W-1:0] table_x [MAX_POINTS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   depletion_curve_interpolator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   curve_lookup_check lookup_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .answered          (answered),
      .interpolated_seen (interpolated_seen)
   );

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [IDX_W-1:0] idx,
                                                      input logic [Q_W-1:0] px,
                                                      input logic [Q_W-1:0] py,
                                                      input logic [Q_W-1:0] q);
      return REQ_DATA_W'({q, py, px, idx});
   endfunction

   task automatic send_beat(input logic cmd, input logic [REQ_DATA_W-1:0] data);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_load(input int idx, input int px, input int py);
      table_x[idx] = Q_W'(px);
      loads_sent++;
      send_beat(CMD_LOAD, pack_req(IDX_W'(idx), Q_W'(px), Q_W'(py),
                                   Q_W'($urandom_range(131071))));
   endtask

   task automatic send_query(input int q);
      queries_sent++;
      send_beat(CMD_QUERY, pack_req(IDX_W'($urandom_range(15)), Q_W'($urandom_range(131071)),
                                    Q_W'($urandom_range(131071)), Q_W'(q)));
   endtask

   task automatic set_count(input int value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CFG_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      settings_seen++;
   endtask

   task automatic random_item();
      int idx, r, px, py, q;
      if ($urandom_range(99) < 25) begin
         idx = $urandom_range(15);
         r = $urandom_range(9);
         if (r < 7) begin
            px = idx * 4096 + $urandom_range(4095);
            py = $urandom_range(65536);
         end else if (r < 9) begin
            px = $urandom_range(65536);
            py = $urandom_range(65536);
         end else begin
            px = $urandom_range(131071);
            py = $urandom_range(131071);
         end
         send_load(idx, px, py);
      end else begin
         r = $urandom_range(99);
         if (r < 6) begin
            q = 0;
         end else if (r < 14) begin
            q = $urandom_range(131071, 65536);
         end else if (r < 34) begin
            q = (int'(table_x[$urandom_range(15)]) + $urandom_range(2) - 1) & 32'h1FFFF;
         end else begin
            q = $urandom_range(65535, 1);
         end
         send_query(q);
      end
   endtask

   initial begin
      bit stall_done;
      stall_done = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 36);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int count_plan [8];
      count_plan = '{16, 31, 5, 0, 17, 1, 9, 16};
      count_plan[2] = $urandom_range(15, 2);
      count_plan[6] = $urandom_range(15, 2);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // One point in use: the clamps at zero and one, and the fallback above one.
      set_count(1);
      send_load(0, 3000, 70000);
      send_query(0);
      send_query(65536);
      send_query(131071);
      send_query(1);

      // A count of zero behaves as a single point.
      set_count(0);
      send_query(65535);

      // Two points: equal x, a reversed segment that goes negative, the
      // fallback past the last x and an ordinary rising segment.
      set_count(2);
      send_load(0, 3000, 12000);
      send_load(1, 3000, 50000);
      send_query(2000);
      send_query(3000);
      send_load(1, 1000, 0);
      send_query(500);
      send_query(4000);
      send_load(1, 20000, 50000);
      send_query(10000);
      send_query(20000);

      for (int i = 0; i < MAX_POINTS; i++) begin
         send_load(i, i * 4096 + $urandom_range(4095), $urandom_range(65536));
      end

      for (int phase_no = 0; phase_no < 8; phase_no++) begin
         set_count(count_plan[phase_no]);
         quiet = (phase_no == 2);
         for (int k = 0; k < 128; k++) begin
            if (phase_no == 4 && k == 8) begin
               stall_request = 1'b1;
            end
            random_item();
         end
      end
      quiet = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(negedge clock);

      $display("Run covered %0d point loads and %0d queries over %0d point-count settings.",
               loads_sent, queries_sent, settings_seen);
      $display("%0d results were checked, %0d of them from an interpolated segment.",
               answered, interpolated_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
